// ===== sv/drrip_ship_stream_bypass_replacement_defines.svh =====
// Assertion helpers shared by the replacement block.
`ifndef DRRIP_SHIP_STREAM_BYPASS_REPLACEMENT_DEFINES_SVH
`define DRRIP_SHIP_STREAM_BYPASS_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define DRRIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define DRRIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/drrip_pkg.sv =====
package drrip_pkg;

    localparam int ADDR_W   = 64;
    localparam int VICTIM_W = 4;
    localparam int MASK_W   = 16;

    localparam logic [0:0] CMD_VICTIM = 1'b0;
    localparam logic [0:0] CMD_UPDATE = 1'b1;

    localparam logic [1:0] AGE_MAX   = 2'd3;
    localparam logic [1:0] AGE_SRRIP = 2'd2;
    localparam logic [1:0] AGE_HOT   = 2'd0;
    localparam logic [1:0] CTR_MAX   = 2'd3;
    localparam logic [1:0] CTR_INIT  = 2'd1;
    localparam logic [1:0] CTR_WEAK  = 2'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef enum logic [1:0] {
        LEAD_FOLLOW,
        LEAD_SRRIP,
        LEAD_BRRIP
    } t_leader;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_INC,
        SEL_DEC
    } t_sel_op;

    typedef struct packed {
        logic    hist_we;
        t_sel_op sel_op;
    } t_calc_ctl;

    typedef struct packed {
        logic [0:0]        cmd;
        logic [10:0]       set_index;
        logic [3:0]        way;
        logic [MASK_W-1:0] valid_mask;
        logic [ADDR_W-1:0] address;
        logic [12:0]       pc;
        logic              hit;
        logic [4:0]        brrip_draw;
    } t_req;

    typedef struct packed {
        logic [VICTIM_W-1:0] victim_way;
        logic                stream_seen;
        logic                bypassed;
        logic [1:0]          inserted_age;
    } t_rsp;

endpackage

// ===== sv/drrip_stream_if.sv =====
interface drrip_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/drrip_ram.sv =====
module drrip_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/drrip_calc.sv =====
module drrip_calc
    import drrip_pkg::*;
#(
    parameter int WAYS     = 16,
    parameter int HIST_LEN = 4,
    localparam int WayW  = $clog2(WAYS),
    localparam int PtrW  = $clog2(HIST_LEN),
    localparam int MetaW = 4 * WAYS + PtrW,
    localparam int HistW = HIST_LEN * ADDR_W
) (
    input  t_req             i_req,
    input  logic [WayW-1:0]  i_way,
    input  t_leader          i_kind,
    input  logic             i_sel_high,
    input  logic [MetaW-1:0] i_meta,
    input  logic [HistW-1:0] i_hist,
    output logic [MetaW-1:0] o_meta,
    output logic [HistW-1:0] o_hist,
    output t_calc_ctl        o_ctl,
    output t_rsp             o_rsp
);

    logic [WAYS-1:0][1:0]              ages;
    logic [WAYS-1:0][1:0]              ctrs;
    logic [WAYS-1:0][1:0]              ages_aged;
    logic [WAYS-1:0][1:0]              ages_upd;
    logic [WAYS-1:0][1:0]              ctrs_upd;
    logic [PtrW-1:0]                   ptr;
    logic [PtrW-1:0]                   ptr_next;
    logic [HIST_LEN-1:0][ADDR_W-1:0]   hist_new;
    logic [ADDR_W-1:0]                 first_delta;
    logic                              same_all;
    logic                              wrap;
    logic                              stream;
    logic [WAYS+MASK_W-1:0]            mask_ext;
    logic [WAYS-1:0]                   way_free;
    logic                              any_free;
    logic                              max_hi;
    logic                              max_lo;
    logic [1:0]                        age_inc;
    logic [WayW-1:0]                   free_way;
    logic [WayW-1:0]                   aged_way;
    logic [1:0]                        ctr_old;
    logic [1:0]                        ctr_dec;
    logic [1:0]                        bim_age;
    logic [1:0]                        miss_age;
    logic                              bypass;

    assign {ptr, ctrs, ages} = i_meta;

    // victim: first empty way, else age the set until a way reaches max
    assign mask_ext = {{WAYS{1'b1}}, i_req.valid_mask};
    assign way_free = ~mask_ext[WAYS-1:0];
    assign any_free = |way_free;

    always_comb begin
        max_hi = 1'b0;
        max_lo = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            max_hi = max_hi | ages[w][1];
        end
        for (int w = 0; w < WAYS; w++) begin
            if (ages[w][1] == max_hi) begin
                max_lo = max_lo | ages[w][0];
            end
        end
        age_inc = AGE_MAX - {max_hi, max_lo};
        for (int w = 0; w < WAYS; w++) begin
            ages_aged[w] = ages[w] + age_inc;
        end
        free_way = '0;
        aged_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_free[w]) begin
                free_way = WayW'(w);
            end
            if (ages_aged[w] == AGE_MAX) begin
                aged_way = WayW'(w);
            end
        end
    end

    // stream check runs once the history pointer wraps
    always_comb begin
        hist_new = i_hist;
        for (int i = 0; i < HIST_LEN; i++) begin
            if (ptr == PtrW'(i)) begin
                hist_new[i] = i_req.address;
            end
        end
        first_delta = hist_new[1] - hist_new[0];
        same_all    = 1'b1;
        for (int i = 2; i < HIST_LEN; i++) begin
            if ((hist_new[i] - hist_new[i-1]) != first_delta) begin
                same_all = 1'b0;
            end
        end
        wrap     = (ptr == PtrW'(HIST_LEN - 1));
        stream   = wrap & same_all;
        ptr_next = wrap ? '0 : ptr + 1'b1;
    end

    // insertion age for a miss fill
    always_comb begin
        ctr_old = ctrs[i_way];
        ctr_dec = (ctr_old != 2'd0) ? ctr_old - 2'd1 : 2'd0;
        bim_age = (i_req.brrip_draw == '0) ? AGE_SRRIP : AGE_MAX;
        case (i_kind)
            LEAD_SRRIP:  miss_age = AGE_SRRIP;
            LEAD_BRRIP:  miss_age = bim_age;
            default:     miss_age = i_sel_high ? AGE_SRRIP : bim_age;
        endcase
        if (ctr_dec > CTR_WEAK) begin
            miss_age = AGE_HOT;
        end
        bypass = stream && (ctr_dec <= CTR_WEAK);
    end

    always_comb begin
        o_meta   = i_meta;
        o_hist   = hist_new;
        o_ctl    = '{hist_we: 1'b0, sel_op: SEL_HOLD};
        o_rsp    = '0;
        ages_upd = ages;
        ctrs_upd = ctrs;
        case (i_req.cmd)
            CMD_VICTIM: begin
                o_rsp.victim_way = VICTIM_W'(any_free ? free_way : aged_way);
                if (!any_free) begin
                    o_meta = {ptr, ctrs, ages_aged};
                end
            end
            CMD_UPDATE: begin
                o_ctl.hist_we     = 1'b1;
                o_rsp.stream_seen = stream;
                if (i_req.hit) begin
                    ages_upd[i_way] = AGE_HOT;
                    ctrs_upd[i_way] = (ctr_old == CTR_MAX) ? CTR_MAX : ctr_old + 2'd1;
                end else begin
                    ctrs_upd[i_way] = CTR_INIT;
                    if (bypass) begin
                        ages_upd[i_way]    = AGE_MAX;
                        o_rsp.bypassed     = 1'b1;
                        o_rsp.inserted_age = AGE_MAX;
                    end else begin
                        ages_upd[i_way]    = miss_age;
                        o_rsp.inserted_age = miss_age;
                        case (i_kind)
                            LEAD_SRRIP: o_ctl.sel_op = SEL_DEC;
                            LEAD_BRRIP: o_ctl.sel_op = SEL_INC;
                            default:    o_ctl.sel_op = SEL_HOLD;
                        endcase
                    end
                end
                o_meta = {ptr_next, ctrs_upd, ages_upd};
            end
            default: begin
                o_meta = i_meta;
            end
        endcase
    end

endmodule

// ===== sv/drrip_ship_stream_bypass_replacement.sv =====
// Replacement policy for a set-associative cache: DRRIP insertion with set
// dueling, a per-way reuse counter and a per-set constant-stride stream
// detector that can bypass miss fills. Every request (victim or update)
// returns exactly one response. Accepting a request issues the read of
// the set's metadata and history rows from two synchronous memories; the
// execute state computes the response and writes the metadata row back,
// plus the history row for an update. Only one request is in flight, so
// the next request is accepted the cycle after write-back; a response
// waiting in the output register does not block acceptance, only the
// write-back of the following request. After reset, a clearing pass walks
// the metadata memory one set per cycle (SETS sets, 2048 by default) and
// no request is accepted until it ends. The per-way signature is not
// stored because no response depends on it, so pc does not affect results.
`include "drrip_ship_stream_bypass_replacement_defines.svh"

module drrip_ship_stream_bypass_replacement
    import drrip_pkg::*;
#(
    parameter int SETS           = 2048,
    parameter int WAYS           = 16,
    parameter int LEADERS        = 32,
    parameter int HIST_LEN       = 4,
    parameter int SELECTOR_WIDTH = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    drrip_stream_if.sink   i_req,
    drrip_stream_if.source o_rsp
);

    localparam int SetW    = $clog2(SETS);
    localparam int WayW    = $clog2(WAYS);
    localparam int PtrW    = $clog2(HIST_LEN);
    localparam int MetaW   = 4 * WAYS + PtrW;
    localparam int HistW   = HIST_LEN * ADDR_W;
    localparam int RemW    = SetW + 4;
    localparam int WayRemW = WayW + 4;

    localparam logic [RemW-1:0]           SetsExt  = RemW'(SETS);
    localparam logic [WayRemW-1:0]        WaysExt  = WayRemW'(WAYS);
    localparam logic [SetW-1:0]           ClrLast  = SetW'(SETS - 1);
    localparam logic [SELECTOR_WIDTH-1:0] SelHalf  =
        {1'b1, {(SELECTOR_WIDTH-1){1'b0}}};
    localparam logic [MetaW-1:0]          MetaInit =
        {PtrW'(0), {WAYS{CTR_INIT}}, {WAYS{AGE_MAX}}};

    t_state                    r_state;
    t_state                    n_state;
    logic [SetW-1:0]           r_clr_idx;
    logic [SetW-1:0]           n_clr_idx;
    logic [SELECTOR_WIDTH-1:0] r_sel;
    logic [SELECTOR_WIDTH-1:0] n_sel;
    logic                      r_rsp_valid;
    logic                      n_rsp_valid;
    t_req                      r_req;
    logic [SetW-1:0]           r_set;
    t_rsp                      r_rsp;

    logic                      req_ready;
    logic                      req_accept;
    logic                      clearing;
    logic                      exec_go;
    logic [RemW-1:0]           set_rem;
    logic [SetW-1:0]           set_mod;
    logic [WayRemW-1:0]        way_rem;
    logic [WayW-1:0]           way_idx;
    logic [LEADERS-1:0]        srrip_hit;
    logic [LEADERS-1:0]        brrip_hit;
    t_leader                   kind;

    logic [MetaW-1:0]          meta_rdata;
    logic [MetaW-1:0]          meta_wdata;
    logic [SetW-1:0]           meta_waddr;
    logic                      meta_we;
    logic [HistW-1:0]          hist_rdata;
    logic [HistW-1:0]          hist_wdata;
    logic                      hist_we;
    logic [MetaW-1:0]          calc_meta;
    t_calc_ctl                 calc_ctl;
    t_rsp                      calc_rsp;

    // set index modulo SETS: quotient stays below 16, so four
    // compare-and-subtract steps are enough
    always_comb begin
        set_rem = RemW'(i_req.payload.set_index);
        for (int k = 3; k >= 0; k--) begin
            if (set_rem >= (SetsExt << k)) begin
                set_rem = set_rem - (SetsExt << k);
            end
        end
    end
    assign set_mod = set_rem[SetW-1:0];

    // way modulo WAYS: quotient stays below 8
    always_comb begin
        way_rem = WayRemW'(r_req.way);
        for (int k = 2; k >= 0; k--) begin
            if (way_rem >= (WaysExt << k)) begin
                way_rem = way_rem - (WaysExt << k);
            end
        end
    end
    assign way_idx = way_rem[WayW-1:0];

    // leader sets: SRRIP leaders sit in the lower half, BRRIP leaders the
    // same offsets in the upper half
    for (genvar gi = 0; gi < LEADERS; gi++) begin : g_lead
        localparam int LeadSet = (gi * SETS) / (2 * LEADERS);
        assign srrip_hit[gi] = (r_set == SetW'(LeadSet));
        assign brrip_hit[gi] = (r_set == SetW'(LeadSet + SETS / 2));
    end

    always_comb begin
        if (|srrip_hit) begin
            kind = LEAD_SRRIP;
        end else if (|brrip_hit) begin
            kind = LEAD_BRRIP;
        end else begin
            kind = LEAD_FOLLOW;
        end
    end

    // next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == ClrLast) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        req_ready = 1'b0;
        clearing  = 1'b0;
        exec_go   = 1'b0;
        case (r_state)
            ST_CLEAR: clearing  = 1'b1;
            ST_IDLE:  req_ready = 1'b1;
            ST_EXEC:  exec_go   = !r_rsp_valid || o_rsp.ready;
            default:  clearing  = 1'b0;
        endcase
    end

    assign req_accept  = i_req.valid && req_ready;
    assign i_req.ready = req_ready;

    // write-back: the clearing pass owns the metadata port until it ends
    assign meta_we    = clearing || exec_go;
    assign meta_waddr = clearing ? r_clr_idx : r_set;
    assign meta_wdata = clearing ? MetaInit : calc_meta;
    assign hist_we    = exec_go && calc_ctl.hist_we;

    assign n_clr_idx = clearing ? r_clr_idx + 1'b1 : r_clr_idx;

    // hold a response until taken, load the next one on write-back
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (exec_go) begin
            n_rsp_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    // saturating selector, moved only by non-bypassed leader misses
    always_comb begin
        n_sel = r_sel;
        if (exec_go) begin
            case (calc_ctl.sel_op)
                SEL_INC: begin
                    if (r_sel != '1) begin
                        n_sel = r_sel + 1'b1;
                    end
                end
                SEL_DEC: begin
                    if (r_sel != '0) begin
                        n_sel = r_sel - 1'b1;
                    end
                end
                default: n_sel = r_sel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_sel       <= SelHalf;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_sel       <= n_sel;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_req <= i_req.payload;
            r_set <= set_mod;
        end
        if (exec_go) begin
            r_rsp <= calc_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // per-set ages, reuse counters and history pointer
    drrip_ram #(
        .DEPTH (SETS),
        .WIDTH (MetaW)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_re    (req_accept),
        .i_raddr (set_mod),
        .o_rdata (meta_rdata),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata)
    );

    // per-set address history; entries fill in order from the pointer,
    // so every entry is written before the wrap that first reads it
    drrip_ram #(
        .DEPTH (SETS),
        .WIDTH (HistW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_re    (req_accept),
        .i_raddr (set_mod),
        .o_rdata (hist_rdata),
        .i_we    (hist_we),
        .i_waddr (r_set),
        .i_wdata (hist_wdata)
    );

    drrip_calc #(
        .WAYS     (WAYS),
        .HIST_LEN (HIST_LEN)
    ) u_calc (
        .i_req      (r_req),
        .i_way      (way_idx),
        .i_kind     (kind),
        .i_sel_high (r_sel[SELECTOR_WIDTH-1]),
        .i_meta     (meta_rdata),
        .i_hist     (hist_rdata),
        .o_meta     (calc_meta),
        .o_hist     (hist_wdata),
        .o_ctl      (calc_ctl),
        .o_rsp      (calc_rsp)
    );

    // one request in flight: an accepted request always goes to execute
    `DRRIP_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, req_accept,
        (r_state == ST_EXEC) && !i_req.ready, "accepted request did not enter execute")

    // write-back always leaves a response in the output register
    `DRRIP_ASSERT_NEXT(a_exec_rsp, i_clk, i_rst_n, exec_go,
        r_rsp_valid, "write-back produced no response")

    // the selector moves only on a write-back
    `DRRIP_ASSERT_NOW(a_sel_move, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_sel),
        $past(exec_go), "selector changed without a write-back")

endmodule
